/* hdl/mte_pkg.sv */
// shared types and codes for the midi track event parser
// no dependencies; used by mte_step, midi_track_event_parser and mte_checker
package mte_pkg;

  localparam int ACC_W = 28;
  localparam int CNT_W = 3;

  // event kinds
  localparam logic [2:0] KIND_CHANNEL  = 3'd0;
  localparam logic [2:0] KIND_TEMPO    = 3'd1;
  localparam logic [2:0] KIND_TIME_SIG = 3'd2;
  localparam logic [2:0] KIND_KEY_SIG  = 3'd3;
  localparam logic [2:0] KIND_END      = 3'd4;
  localparam logic [2:0] KIND_ERROR    = 3'd5;

  // error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_NO_RUNNING = 2'd1;
  localparam logic [1:0] ERR_SYSTEM     = 2'd2;

  // bit n set when status class n (status[6:4]) takes two data bytes
  localparam logic [7:0] TWO_DATA_TAB = 8'b1100_1111;

  typedef struct packed {
    logic [3:0]       phase;
    logic [ACC_W-1:0] delta_accum;
    logic [CNT_W-1:0] varlen_count;
    logic [7:0]       running_status;
    logic [7:0]       event_status;
    logic [6:0]       first_data;
    logic [7:0]       meta_kind;
    logic [ACC_W-1:0] bytes_left;
    logic [31:0]      payload_shift;
    logic [CNT_W-1:0] payload_count;
    logic             seen_time_sig;
    logic             seen_key_sig;
  } mte_state_t;

  typedef struct packed {
    logic             valid;
    logic [2:0]       kind;
    logic [ACC_W-1:0] delta_ticks;
    logic [7:0]       status;
    logic [6:0]       data_one;
    logic [6:0]       data_two;
    logic [23:0]      tempo_us;
    logic [31:0]      sig_word;
    logic [1:0]       error_code;
  } mte_result_t;

endpackage

/* hdl/midi_track_event_parser.sv */
// top level of the midi track event parser: byte register, parser state,
// event register; depends on mte_pkg and mte_step
//
// Takes the data bytes of MIDI track chunks one word per cycle and emits
// decoded events: channel messages with running status applied, set tempo
// every time, the first time and key signature since reset, end of track,
// and a single error word after which every byte is swallowed until reset.
// Delta times and lengths are variable-length numbers of at most
// MAX_VARLEN_BYTES bytes. One byte is parsed per cycle: an incoming byte is
// held in a byte register and, in the cycle it is parsed, the state update
// and the event word are computed by one pass of the step logic into the
// parser state and the event register. A byte's event word thus passes
// through the byte and event registers, and bytes stream at one per cycle as
// long as the event side keeps up; a stalled event holds the byte register,
// and byte_stall follows in the same cycle.
module midi_track_event_parser #(
  parameter int MAX_VARLEN_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  // byte channel
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  track_byte,
  // event channel
  output logic        event_valid,
  input  logic        event_stall,
  output logic [2:0]  kind,
  output logic [27:0] delta_ticks,
  output logic [7:0]  status,
  output logic [6:0]  data_one,
  output logic [6:0]  data_two,
  output logic [23:0] tempo_us,
  output logic [31:0] sig_word,
  output logic [1:0]  error_code
);

  // byte register
  logic                 byte_full;
  logic [7:0]           byte_q;
  // parser state and step outputs
  mte_pkg::mte_state_t  state;
  mte_pkg::mte_state_t  state_next;
  mte_pkg::mte_result_t result;
  logic                 advance;
  logic                 byte_take;

  // parse the held byte when the event register is empty or being drained
  assign advance    = byte_full && (!event_valid || !event_stall);
  assign byte_stall = byte_full && !advance;
  assign byte_take  = byte_valid && !byte_stall;

  mte_step #(
    .MAX_VARLEN_BYTES(MAX_VARLEN_BYTES)
  ) u_step (
    .state      (state),
    .track_byte (byte_q),
    .state_next (state_next),
    .result     (result)
  );

  // byte register: refilled in the same cycle it is parsed
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_full <= 1'b0;
    end else if (byte_take) begin
      byte_full <= 1'b1;
    end else if (advance) begin
      byte_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      byte_q <= track_byte;
    end
  end

  // parser state: every field clears on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // event register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (advance && result.valid) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      kind        <= result.kind;
      delta_ticks <= result.delta_ticks;
      status      <= result.status;
      data_one    <= result.data_one;
      data_two    <= result.data_two;
      tempo_us    <= result.tempo_us;
      sig_word    <= result.sig_word;
      error_code  <= result.error_code;
    end
  end

endmodule

/* hdl/mte_step.sv */
// one parse step: parser state and one track byte give the next state and
// at most one event word; depends on mte_pkg
module mte_step #(
  parameter int MAX_VARLEN_BYTES = 4
) (
  input  mte_pkg::mte_state_t  state,
  input  logic [7:0]           track_byte,
  output mte_pkg::mte_state_t  state_next,
  output mte_pkg::mte_result_t result
);

  localparam logic [3:0] PH_DELTA      = 4'd0;
  localparam logic [3:0] PH_STATUS     = 4'd1;
  localparam logic [3:0] PH_DATA1      = 4'd2;
  localparam logic [3:0] PH_DATA2      = 4'd3;
  localparam logic [3:0] PH_META_TYPE  = 4'd4;
  localparam logic [3:0] PH_META_LEN   = 4'd5;
  localparam logic [3:0] PH_META_DATA  = 4'd6;
  localparam logic [3:0] PH_SYSEX_LEN  = 4'd7;
  localparam logic [3:0] PH_SYSEX_DATA = 4'd8;
  localparam logic [3:0] PH_HALT       = 4'd9;

  localparam logic [7:0] ST_META    = 8'hff;
  localparam logic [7:0] ST_SYSEX   = 8'hf0;
  localparam logic [7:0] ST_ESCAPE  = 8'hf7;
  localparam logic [7:0] META_END   = 8'h2f;
  localparam logic [7:0] META_TEMPO = 8'h51;
  localparam logic [7:0] META_TIME  = 8'h58;
  localparam logic [7:0] META_KEY   = 8'h59;

  localparam logic [mte_pkg::CNT_W-1:0] MAX_CNT = mte_pkg::CNT_W'(MAX_VARLEN_BYTES);

  logic [mte_pkg::ACC_W-1:0] delta_shifted;
  logic [mte_pkg::ACC_W-1:0] len_shifted;
  logic [mte_pkg::CNT_W-1:0] cnt_inc;
  logic                      vl_done;
  logic                      two_data;
  logic                      two_data_run;
  logic [31:0]               shift_new;
  logic [mte_pkg::ACC_W-1:0] left_dec;
  logic                      finish;
  logic                      channel;
  logic [6:0]                second;
  logic                      restart;

  assign delta_shifted = {state.delta_accum[mte_pkg::ACC_W-8:0], track_byte[6:0]};
  assign len_shifted   = {state.bytes_left[mte_pkg::ACC_W-8:0], track_byte[6:0]};
  assign cnt_inc       = state.varlen_count + 1'b1;
  assign vl_done       = !track_byte[7] || (cnt_inc >= MAX_CNT);
  assign two_data      = mte_pkg::TWO_DATA_TAB[state.event_status[6:4]];
  assign two_data_run  = mte_pkg::TWO_DATA_TAB[state.running_status[6:4]];
  assign left_dec      = state.bytes_left - 1'b1;

  // meta payload insertion: tempo big endian, signatures first byte lowest
  always_comb begin
    shift_new = state.payload_shift;
    if (state.meta_kind == META_TEMPO) begin
      case (state.payload_count)
        3'd0:    shift_new[23:16] = shift_new[23:16] | track_byte;
        3'd1:    shift_new[15:8]  = shift_new[15:8]  | track_byte;
        3'd2:    shift_new[7:0]   = shift_new[7:0]   | track_byte;
        default: shift_new = state.payload_shift;
      endcase
    end else begin
      case (state.payload_count)
        3'd0:    shift_new[7:0]   = shift_new[7:0]   | track_byte;
        3'd1:    shift_new[15:8]  = shift_new[15:8]  | track_byte;
        3'd2:    shift_new[23:16] = shift_new[23:16] | track_byte;
        3'd3:    shift_new[31:24] = shift_new[31:24] | track_byte;
        default: shift_new = state.payload_shift;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    result     = '0;
    finish     = 1'b0;
    channel    = 1'b0;
    second     = 7'd0;
    restart    = 1'b0;
    result.delta_ticks = state.delta_accum;

    case (state.phase)
      PH_DELTA: begin
        state_next.delta_accum  = delta_shifted;
        state_next.varlen_count = cnt_inc;
        if (vl_done) state_next.phase = PH_STATUS;
      end
      PH_STATUS: begin
        if (track_byte == ST_META) begin
          state_next.running_status = 8'd0;
          state_next.phase          = PH_META_TYPE;
        end else if (track_byte == ST_SYSEX || track_byte == ST_ESCAPE) begin
          state_next.running_status = 8'd0;
          state_next.bytes_left     = '0;
          state_next.varlen_count   = '0;
          state_next.phase          = PH_SYSEX_LEN;
        end else if (track_byte[7:4] == 4'hf) begin
          result.valid      = 1'b1;
          result.kind       = mte_pkg::KIND_ERROR;
          result.error_code = mte_pkg::ERR_SYSTEM;
          state_next.phase  = PH_HALT;
        end else if (track_byte[7]) begin
          state_next.running_status = track_byte;
          state_next.event_status   = track_byte;
          state_next.phase          = PH_DATA1;
        end else if (state.running_status == 8'd0) begin
          result.valid      = 1'b1;
          result.kind       = mte_pkg::KIND_ERROR;
          result.error_code = mte_pkg::ERR_NO_RUNNING;
          state_next.phase  = PH_HALT;
        end else begin
          state_next.event_status = state.running_status;
          state_next.first_data   = track_byte[6:0];
          if (two_data_run) state_next.phase = PH_DATA2;
          else channel = 1'b1;
        end
      end
      PH_DATA1: begin
        state_next.first_data = track_byte[6:0];
        if (two_data) state_next.phase = PH_DATA2;
        else channel = 1'b1;
      end
      PH_DATA2: begin
        channel = 1'b1;
        second  = track_byte[6:0];
      end
      PH_META_TYPE: begin
        state_next.meta_kind     = track_byte;
        state_next.bytes_left    = '0;
        state_next.varlen_count  = '0;
        state_next.payload_shift = 32'd0;
        state_next.payload_count = '0;
        state_next.phase         = PH_META_LEN;
      end
      PH_META_LEN: begin
        state_next.bytes_left   = len_shifted;
        state_next.varlen_count = cnt_inc;
        if (vl_done) begin
          if (len_shifted == '0) finish = 1'b1;
          else state_next.phase = PH_META_DATA;
        end
      end
      PH_META_DATA: begin
        state_next.payload_shift = shift_new;
        if (state.payload_count < 3'd4) state_next.payload_count = state.payload_count + 1'b1;
        state_next.bytes_left = left_dec;
        if (left_dec == '0) finish = 1'b1;
      end
      PH_SYSEX_LEN: begin
        state_next.bytes_left   = len_shifted;
        state_next.varlen_count = cnt_inc;
        if (vl_done) begin
          if (len_shifted == '0) restart = 1'b1;
          else state_next.phase = PH_SYSEX_DATA;
        end
      end
      PH_SYSEX_DATA: begin
        state_next.bytes_left = left_dec;
        if (left_dec == '0) restart = 1'b1;
      end
      default: begin
        state_next = state;
      end
    endcase

    // channel message complete
    if (channel) begin
      result.valid    = 1'b1;
      result.kind     = mte_pkg::KIND_CHANNEL;
      result.status   = state_next.event_status;
      result.data_one = state_next.first_data;
      result.data_two = second;
      restart         = 1'b1;
    end

    // meta event complete, report the kinds we keep
    if (finish) begin
      restart = 1'b1;
      case (state.meta_kind)
        META_END: begin
          state_next.running_status = 8'd0;
          result.valid = 1'b1;
          result.kind  = mte_pkg::KIND_END;
        end
        META_TEMPO: begin
          result.valid    = 1'b1;
          result.kind     = mte_pkg::KIND_TEMPO;
          result.tempo_us = state_next.payload_shift[23:0];
        end
        META_TIME: begin
          if (!state.seen_time_sig) begin
            state_next.seen_time_sig = 1'b1;
            result.valid    = 1'b1;
            result.kind     = mte_pkg::KIND_TIME_SIG;
            result.sig_word = state_next.payload_shift;
          end
        end
        META_KEY: begin
          if (!state.seen_key_sig) begin
            state_next.seen_key_sig = 1'b1;
            result.valid    = 1'b1;
            result.kind     = mte_pkg::KIND_KEY_SIG;
            result.sig_word = {16'd0, state_next.payload_shift[15:0]};
          end
        end
        default: begin
          result.valid = 1'b0;
        end
      endcase
    end

    if (restart) begin
      state_next.phase        = PH_DELTA;
      state_next.delta_accum  = '0;
      state_next.varlen_count = '0;
    end
  end

endmodule

/* hdl/mte_checker.sv */
// port level checks for midi_track_event_parser, bound to the top level
// depends on mte_pkg
module mte_checker (
  input logic        clk,
  input logic        rst,
  input logic        event_valid,
  input logic        event_stall,
  input logic [2:0]  kind,
  input logic [7:0]  status,
  input logic [23:0] tempo_us,
  input logic [1:0]  error_code
);

  // a stalled event word holds
  a_event_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_stall |=> event_valid && $stable(kind) && $stable(status))
    else $error("event word changed while stalled");

  // error codes only on error words, and never none there
  a_error_code: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> ((kind == mte_pkg::KIND_ERROR) == (error_code != mte_pkg::ERR_NONE)))
    else $error("error code does not match event kind");

  // channel events carry a channel status byte
  a_channel_status: assert property (@(posedge clk) disable iff (rst)
    event_valid && kind == mte_pkg::KIND_CHANNEL |-> status[7] && status[7:4] != 4'hf)
    else $error("channel event without channel status");

  // tempo field is zero except on tempo words
  a_tempo_zero: assert property (@(posedge clk) disable iff (rst)
    event_valid && kind != mte_pkg::KIND_TEMPO |-> tempo_us == 24'd0)
    else $error("tempo field set on non-tempo event");

endmodule

bind midi_track_event_parser mte_checker u_mte_checker (
  .clk         (clk),
  .rst         (rst),
  .event_valid (event_valid),
  .event_stall (event_stall),
  .kind        (kind),
  .status      (status),
  .tempo_us    (tempo_us),
  .error_code  (error_code)
);

/* tb/tb.sv */
`timescale 1ns / 100ps
// testbench for midi_track_event_parser: drives track bytes, predicts every event word
// and checks it field by field; depends on mte_pkg and the parser rtl only
module tb;

  localparam int MAX_VARLEN   = 4;
  localparam int RANDOM_BYTES = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;

  // status bytes
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] ST_PROGRAM   = 8'hC0;

  // meta event types
  localparam logic [7:0] META_END      = 8'h2F;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [7:0] META_TIME_SIG = 8'h58;
  localparam logic [7:0] META_KEY_SIG  = 8'h59;

  // status classes (bits 6:4) that carry a single data byte
  localparam logic [2:0] CLASS_PROGRAM  = 3'd4;
  localparam logic [2:0] CLASS_PRESSURE = 3'd5;

  typedef enum logic [3:0] {
    SEEK_DELTA,
    SEEK_STATUS,
    SEEK_DATA1,
    SEEK_DATA2,
    SEEK_META_TYPE,
    SEEK_META_LEN,
    META_BODY,
    SEEK_SYSEX_LEN,
    SYSEX_BODY,
    HALTED
  } parse_phase_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        byte_valid  = 1'b0;
  logic        byte_stall;
  logic [7:0]  track_byte  = 8'h00;
  logic        event_valid;
  logic        event_stall = 1'b0;
  logic [2:0]  kind;
  logic [27:0] delta_ticks;
  logic [7:0]  status;
  logic [6:0]  data_one;
  logic [6:0]  data_two;
  logic [23:0] tempo_us;
  logic [31:0] sig_word;
  logic [1:0]  error_code;

  // 12 ns period
  always #6 clk = ~clk;

  midi_track_event_parser #(
    .MAX_VARLEN_BYTES(MAX_VARLEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .track_byte(track_byte),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .kind(kind),
    .delta_ticks(delta_ticks),
    .status(status),
    .data_one(data_one),
    .data_two(data_two),
    .tempo_us(tempo_us),
    .sig_word(sig_word),
    .error_code(error_code)
  );

  // ---------------------------------------------------------------------------
  // parser state as the testbench tracks it, advanced once per accepted word
  // ---------------------------------------------------------------------------
  parse_phase_t pr_phase     = SEEK_DELTA;
  logic [27:0]  pr_delta     = '0;
  logic [2:0]   pr_vlen      = '0;
  logic [7:0]   pr_running   = '0;
  logic [7:0]   pr_status    = '0;
  logic [6:0]   pr_first     = '0;
  logic [7:0]   pr_meta      = '0;
  logic [27:0]  pr_left      = '0;
  logic [31:0]  pr_payload   = '0;
  logic [2:0]   pr_pcount    = '0;
  logic         pr_seen_time = 1'b0;
  logic         pr_seen_key  = 1'b0;

  // event words predicted but not yet seen on the output
  mte_pkg::mte_result_t expected_events[$];
  mte_pkg::mte_result_t want_event;

  int errors      = 0;
  int bytes_sent  = 0;

  // sender idling: bursts of words separated by random gaps, when enabled
  bit gaps_on     = 1'b1;
  int burst_left  = 0;

  // receiver long hold-off: the test bumps hold_asked, the receiver serves it
  int hold_asked   = 0;
  int hold_granted = 0;
  int hold_left    = 0;
  int mode_left    = 0;
  int stall_mode   = 0;

  // one more byte of a variable-length number; true when the number is complete,
  // either by a clear top bit or by hitting the length bound
  function automatic logic vlen_last(logic [7:0] b);
    pr_vlen = pr_vlen + 3'd1;
    return !b[7] || pr_vlen >= MAX_VARLEN;
  endfunction

  // program change and channel pressure carry one data byte, everything else two
  function automatic logic takes_two(logic [7:0] st);
    return !(st[6:4] == CLASS_PROGRAM || st[6:4] == CLASS_PRESSURE);
  endfunction

  function automatic void restart_delta();
    pr_phase = SEEK_DELTA;
    pr_delta = '0;
    pr_vlen  = '0;
  endfunction

  // queue an event word; the delta is the one decoded for the current event
  function automatic void expect_event(logic [2:0] k, logic [7:0] st, logic [6:0] d1,
                                       logic [6:0] d2, logic [23:0] tempo,
                                       logic [31:0] sig, logic [1:0] err);
    mte_pkg::mte_result_t ev;
    ev             = '0;
    ev.valid       = 1'b1;
    ev.kind        = k;
    ev.delta_ticks = pr_delta;
    ev.status      = st;
    ev.data_one    = d1;
    ev.data_two    = d2;
    ev.tempo_us    = tempo;
    ev.sig_word    = sig;
    ev.error_code  = err;
    expected_events.push_back(ev);
  endfunction

  function automatic void channel_done(logic [6:0] second);
    expect_event(mte_pkg::KIND_CHANNEL, pr_status, pr_first, second, '0, '0,
                 mte_pkg::ERR_NONE);
    restart_delta();
  endfunction

  // end of a meta event: only a few types produce a word, signatures only once
  function automatic void close_meta();
    case (pr_meta)
      META_END: begin
        pr_running = '0;
        expect_event(mte_pkg::KIND_END, '0, '0, '0, '0, '0, mte_pkg::ERR_NONE);
      end
      META_TEMPO: begin
        expect_event(mte_pkg::KIND_TEMPO, '0, '0, '0, pr_payload[23:0], '0,
                     mte_pkg::ERR_NONE);
      end
      META_TIME_SIG: begin
        if (!pr_seen_time) begin
          pr_seen_time = 1'b1;
          expect_event(mte_pkg::KIND_TIME_SIG, '0, '0, '0, '0, pr_payload,
                       mte_pkg::ERR_NONE);
        end
      end
      META_KEY_SIG: begin
        if (!pr_seen_key) begin
          pr_seen_key = 1'b1;
          expect_event(mte_pkg::KIND_KEY_SIG, '0, '0, '0, '0,
                       {16'h0000, pr_payload[15:0]}, mte_pkg::ERR_NONE);
        end
      end
      default: ;
    endcase
    restart_delta();
  endfunction

  // advance the tracked parser by one accepted byte
  function automatic void parse_byte(logic [7:0] b);
    case (pr_phase)
      SEEK_DELTA: begin
        pr_delta = {pr_delta[20:0], b[6:0]};
        if (vlen_last(b)) pr_phase = SEEK_STATUS;
      end
      SEEK_STATUS: begin
        if (b == ST_META) begin
          pr_running = '0;
          pr_phase   = SEEK_META_TYPE;
        end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
          pr_running = '0;
          pr_left    = '0;
          pr_vlen    = '0;
          pr_phase   = SEEK_SYSEX_LEN;
        end else if (b >= 8'hF0) begin
          // any other system status is fatal
          expect_event(mte_pkg::KIND_ERROR, '0, '0, '0, '0, '0, mte_pkg::ERR_SYSTEM);
          pr_phase = HALTED;
        end else if (b[7]) begin
          pr_running = b;
          pr_status  = b;
          pr_phase   = SEEK_DATA1;
        end else if (pr_running == 8'h00) begin
          // data byte with nothing to run on
          expect_event(mte_pkg::KIND_ERROR, '0, '0, '0, '0, '0, mte_pkg::ERR_NO_RUNNING);
          pr_phase = HALTED;
        end else begin
          // running status: this byte is already the first data byte
          pr_status = pr_running;
          pr_first  = b[6:0];
          if (takes_two(pr_status)) pr_phase = SEEK_DATA2;
          else channel_done('0);
        end
      end
      SEEK_DATA1: begin
        pr_first = b[6:0];
        if (takes_two(pr_status)) pr_phase = SEEK_DATA2;
        else channel_done('0);
      end
      SEEK_DATA2: begin
        channel_done(b[6:0]);
      end
      SEEK_META_TYPE: begin
        pr_meta    = b;
        pr_left    = '0;
        pr_vlen    = '0;
        pr_payload = '0;
        pr_pcount  = '0;
        pr_phase   = SEEK_META_LEN;
      end
      SEEK_META_LEN: begin
        pr_left = {pr_left[20:0], b[6:0]};
        if (vlen_last(b)) begin
          if (pr_left == '0) close_meta();
          else pr_phase = META_BODY;
        end
      end
      META_BODY: begin
        // tempo is big endian over three bytes, signatures little endian over four
        if (pr_meta == META_TEMPO) begin
          if (pr_pcount < 3'd3)
            pr_payload = pr_payload | (32'(b) << (8 * (2 - int'(pr_pcount))));
        end else if (pr_pcount < 3'd4) begin
          pr_payload = pr_payload | (32'(b) << (8 * int'(pr_pcount)));
        end
        if (pr_pcount < 3'd4) pr_pcount = pr_pcount + 3'd1;
        pr_left = pr_left - 28'd1;
        if (pr_left == '0) close_meta();
      end
      SEEK_SYSEX_LEN: begin
        pr_left = {pr_left[20:0], b[6:0]};
        if (vlen_last(b)) begin
          if (pr_left == '0) restart_delta();
          else pr_phase = SYSEX_BODY;
        end
      end
      SYSEX_BODY: begin
        pr_left = pr_left - 28'd1;
        if (pr_left == '0) restart_delta();
      end
      default: ;  // halted: every byte is swallowed
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // byte side
  // ---------------------------------------------------------------------------

  // offer one word, wait for it to be taken, then maybe drop valid for a gap
  task automatic send_byte(input logic [7:0] b);
    byte_valid <= 1'b1;
    track_byte <= b;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    parse_byte(b);
    bytes_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        byte_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // delta time of one to four bytes; now and then all four carry the top bit
  task automatic send_delta();
    int n;
    bit overlong;
    n        = ($urandom_range(0, 3) != 0) ? 1 : $urandom_range(2, MAX_VARLEN);
    overlong = ($urandom_range(0, 15) == 0);
    if (overlong) n = MAX_VARLEN;
    for (int i = 0; i < n; i++) begin
      if (i < n - 1 || overlong) send_byte(8'h80 | 8'($urandom_range(0, 127)));
      else send_byte(8'($urandom_range(0, 127)));
    end
  endtask

  // meta or sysex length: minimal form, a padded two-byte form, or for zero
  // four continuation bytes that only end at the bound
  task automatic send_length(input int len);
    int style;
    style = $urandom_range(0, 9);
    if (len == 0 && style == 0) begin
      repeat (MAX_VARLEN) send_byte(8'h80);
    end else begin
      if (style == 1 || len > 127) send_byte(8'h80 | 8'(len >> 7));
      send_byte(8'(len & 127));
    end
  endtask

  // channel message, with its own status or on running status when there is one
  task automatic send_channel_event();
    if (pr_running != 8'h00 && $urandom_range(0, 2) == 0)
      send_byte(8'($urandom_range(0, 127)));
    else
      send_byte(8'($urandom_range(8'h80, 8'hEF)));
    // data bytes now and then carry a stray top bit, which gets masked
    while (pr_phase == SEEK_DATA1 || pr_phase == SEEK_DATA2)
      send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127)));
  endtask

  task automatic send_meta_event(input logic [7:0] mtype, input int len);
    send_byte(ST_META);
    send_byte(mtype);
    send_length(len);
    repeat (len) send_byte(8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_channel_events();
    logic [7:0] seq[$];
    seq = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h92, 8'h00, 8'h7F,  // longest delta, note on
            8'h7F, 8'h3C, 8'hFF,                              // running status, masked data
            8'h00, 8'hC5, 8'h80,                              // program change, one byte
            8'h00, 8'h21};                                    // running one-byte message
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_meta_and_sysex();
    logic [7:0] seq[$];
    seq = '{8'h00, ST_META, META_TEMPO, 8'h03, 8'hFF, 8'hFF, 8'hFF,   // slowest tempo
            8'h00, ST_META, META_TIME_SIG, 8'h01, 8'hAA,              // short signature
            8'h00, ST_SYSEX_ESC, 8'h02, 8'h12, 8'h34,                 // skipped sysex
            8'h00, ST_META, META_END, 8'h00};                         // end of track
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // mostly well-formed events with random content, some noise in between
  task automatic test_random_track();
    int stop_at;
    int pick;
    int n;
    logic [7:0] b;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 31) == 0) gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // noise, kept clear of the fatal cases and of huge lengths
        repeat ($urandom_range(1, 8)) begin
          b = 8'($urandom);
          if (pr_phase == SEEK_STATUS &&
              ((b >= 8'hF0 && b != ST_META && b != ST_SYSEX && b != ST_SYSEX_ESC) ||
               (!b[7] && pr_running == 8'h00)))
            b = 8'h80 | (b & 8'h6F);
          if (pr_phase == SEEK_META_LEN || pr_phase == SEEK_SYSEX_LEN) b = b & 8'h07;
          send_byte(b);
        end
        // close whatever the noise left open, a half-read delta included,
        // so the next event starts clean
        while (pr_phase != SEEK_DELTA || pr_vlen != 3'd0)
          send_byte((pr_phase == SEEK_STATUS) ? ST_PROGRAM : 8'h00);
      end else begin
        send_delta();
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          send_channel_event();
        end else if (pick < 85) begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : -1;
          case ($urandom_range(0, 4))
            0: send_meta_event(META_TEMPO, (n < 0) ? 3 : n);
            1: send_meta_event(META_TIME_SIG, (n < 0) ? 4 : n);
            2: send_meta_event(META_KEY_SIG, (n < 0) ? 2 : n);
            3: send_meta_event(META_END, (n < 0) ? 0 : n);
            default: send_meta_event(8'($urandom), $urandom_range(0, 10));
          endcase
        end else begin
          send_byte($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC);
          n = ($urandom_range(0, 15) == 0) ? $urandom_range(128, 160) : $urandom_range(0, 12);
          send_length(n);
          repeat (n) send_byte(8'($urandom));
        end
      end
    end
  endtask

  // receiver holds off for a long stretch while words keep coming back to back
  task automatic test_pressure();
    hold_asked++;
    gaps_on = 1'b0;
    repeat (40) begin
      send_delta();
      send_channel_event();
    end
    gaps_on = 1'b1;
  endtask

  // one fatal error, picked at random, then bytes that must all be swallowed
  task automatic test_error_halt();
    logic [7:0] b;
    send_delta();
    if ($urandom_range(0, 1)) begin
      // end of track clears running status, so a bare data byte has nothing to refer to
      send_meta_event(META_END, 0);
      send_delta();
      send_byte(8'($urandom_range(0, 127)));
    end else begin
      b = 8'($urandom_range(8'hF1, 8'hFE));
      if (b == ST_SYSEX_ESC) b = 8'hF8;
      send_byte(b);
    end
    repeat (30) send_byte(8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // event side
  // ---------------------------------------------------------------------------

  // stall pattern: free running, light or heavy random stalls, switching now and
  // then, plus the long hold-off when a test asks for it
  always @(posedge clk) begin
    if (rst) begin
      event_stall <= 1'b0;
    end else if (hold_left > 0) begin
      event_stall <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_asked != hold_granted) begin
      hold_granted <= hold_asked;
      hold_left    <= HOLD_CYCLES;
      event_stall  <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(40, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: event_stall <= 1'b0;
        1: event_stall <= ($urandom_range(0, 3) == 0);
        default: event_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // every accepted event word is matched against the oldest prediction
  always @(posedge clk) begin
    if (!rst && event_valid && !event_stall) begin
      if (expected_events.size() == 0) begin
        $display("%0t: event word expected none got kind %0h", $time, kind);
        errors++;
      end else begin
        want_event = expected_events.pop_front();
        check_field("kind", 32'(want_event.kind), 32'(kind));
        check_field("delta_ticks", 32'(want_event.delta_ticks), 32'(delta_ticks));
        check_field("status", 32'(want_event.status), 32'(status));
        check_field("data_one", 32'(want_event.data_one), 32'(data_one));
        check_field("data_two", 32'(want_event.data_two), 32'(data_two));
        check_field("tempo_us", 32'(want_event.tempo_us), 32'(tempo_us));
        check_field("sig_word", want_event.sig_word, sig_word);
        check_field("error_code", 32'(want_event.error_code), 32'(error_code));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_channel_events();
    test_meta_and_sysex();
    test_random_track();
    test_pressure();
    // the halt lasts until reset, so the error comes last
    test_error_halt();
    byte_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    // give a stray extra word time to show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // overall limit, far above the slowest correct run
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
